// ----- design/mdf_pkg.sv -----
// ----------------------------------------------------------------------------
// mdf_pkg
// Shared types and constants for the MAC address de-duplication filter.
// ----------------------------------------------------------------------------
package mdf_pkg;

    localparam int ADDR_W            = 48;
    localparam int CNT_W             = 16;
    localparam int SEEN_CAPACITY_DEF = 256;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [ADDR_W-1:0] device_address;
        logic              address_ok;
        logic              source_kind;
    } mdf_req_t;

    typedef struct packed {
        logic             is_new;
        logic             cache_flushed;
        logic [CNT_W-1:0] wifi_total;
        logic [CNT_W-1:0] ble_total;
        logic [CNT_W-1:0] flush_total;
    } mdf_res_t;

    // search token passed from cell to cell
    typedef struct packed {
        logic valid;
        logic hit;
    } mdf_link_t;

    // insert request broadcast to the cells
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] data;
    } mdf_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } mdf_state_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- design/mdf_cell.sv -----
// ----------------------------------------------------------------------------
// mdf_cell
// One seen-set entry; compares against the key as the search token passes.
// ----------------------------------------------------------------------------
module mdf_cell
    import mdf_pkg::*;
#(
    parameter int FILL_W   = 9,
    parameter int CELL_IDX = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [FILL_W-1:0]    fill,
    input  logic [ADDR_W-1:0]    key,
    input  mdf_wr_t              wr,
    input  mdf_link_t            link_in,
    output mdf_link_t            link_out
);

    logic [ADDR_W-1:0] entry_reg;
    mdf_link_t         link_reg;
    mdf_link_t         link_next;
    logic              in_use;

    assign in_use = fill > FILL_W'(CELL_IDX);

    always_comb
    begin
        link_next.valid = link_in.valid;
        link_next.hit   = link_in.hit | (link_in.valid & in_use & (entry_reg == key));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg <= '0;
        end
        else
        begin
            link_reg <= link_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (fill == FILL_W'(CELL_IDX)))
        begin
            entry_reg <= wr.data;
        end
    end

    assign link_out = link_reg;

endmodule

// ----- design/mac_address_dedup_filter.sv -----
// ----------------------------------------------------------------------------
// mac_address_dedup_filter
// Seen-set filter for 48-bit device addresses with per-kind new counters.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; busy
//   then stays high until the result is out. Each request gives one result,
//   shown on result for a single cycle with done high; the receiver cannot
//   stall it and must take it in that cycle.
//   The set is a row of SEEN_CAPACITY cells. A search token enters the first
//   cell in the cycle after the request is taken and moves one cell per
//   cycle, so the time to the result grows with the length of the cell row.
//   Only one request is in flight at a time; a new request may follow in the
//   cycle done is high.
//   A full set is emptied when the next request is taken. Reset empties the
//   set and clears all counters; the cell contents are not cleared.
// ----------------------------------------------------------------------------
module mac_address_dedup_filter
    import mdf_pkg::*;
#(
    parameter int SEEN_CAPACITY = SEEN_CAPACITY_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  mdf_req_t request,
    output logic     done,
    output mdf_res_t result
);

    localparam int FILL_W = $clog2(SEEN_CAPACITY + 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(SEEN_CAPACITY);

    mdf_state_t       state_reg, state_next;
    mdf_req_t         req_reg, req_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] wifi_reg, wifi_next;
    logic [CNT_W-1:0] ble_reg, ble_next;
    logic [CNT_W-1:0] flush_reg, flush_next;
    logic             flushed_reg, flushed_next;
    logic             done_reg, done_next;
    mdf_res_t         result_reg, result_next;
    mdf_wr_t          wr;
    logic             fresh;

    mdf_link_t        chain [SEEN_CAPACITY+1];

    assign chain[0].valid = (state_reg == ST_LOAD);
    assign chain[0].hit   = 1'b0;

    for (genvar i = 0; i < SEEN_CAPACITY; i++)
    begin : g_cell
        mdf_cell #(
            .FILL_W   (FILL_W),
            .CELL_IDX (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .fill     (fill_reg),
            .key      (req_reg.device_address),
            .wr       (wr),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    assign fresh = !req_reg.address_ok || !chain[SEEN_CAPACITY].hit;

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        fill_next    = fill_reg;
        wifi_next    = wifi_reg;
        ble_next     = ble_reg;
        flush_next   = flush_reg;
        flushed_next = flushed_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        wr.en        = 1'b0;
        wr.data      = req_reg.device_address;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next     = request;
                    flushed_next = 1'b0;
                    if (fill_reg >= FILL_FULL)
                    begin
                        fill_next    = '0;
                        flush_next   = sat_inc(flush_reg);
                        flushed_next = 1'b1;
                    end
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (chain[SEEN_CAPACITY].valid)
                begin
                    if (fresh)
                    begin
                        if (req_reg.address_ok && (fill_reg < FILL_FULL))
                        begin
                            wr.en     = 1'b1;
                            fill_next = fill_reg + 1'b1;
                        end
                        if (req_reg.source_kind)
                        begin
                            ble_next = sat_inc(ble_reg);
                        end
                        else
                        begin
                            wifi_next = sat_inc(wifi_reg);
                        end
                    end
                    result_next.is_new        = fresh;
                    result_next.cache_flushed = flushed_reg;
                    result_next.wifi_total    = wifi_next;
                    result_next.ble_total     = ble_next;
                    result_next.flush_total   = flush_reg;
                    done_next                 = 1'b1;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            wifi_reg    <= '0;
            ble_reg     <= '0;
            flush_reg   <= '0;
            flushed_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            wifi_reg    <= wifi_next;
            ble_reg     <= ble_next;
            flush_reg   <= flush_next;
            flushed_reg <= flushed_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond capacity");

    a_token_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chain[SEEN_CAPACITY].valid |-> (state_reg == ST_SCAN))
        else $error("search token left chain outside scan");

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("request taken but block not busy");

    a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> done)
        else $error("insert without result");
`endif

endmodule

// ----- sim/mac_address_dedup_filter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_dedup_filter_tb
// Self-checking bench for the address de-duplication filter: directed corner
// requests, a fill of the seen set through its clear, then mixed random
// traffic of fresh, repeated and unparsed addresses from both source kinds.
// Every request is scored against a behavioural copy of the seen set and the
// saturating counters kept in the bench.
// ----------------------------------------------------------------------------
module mac_address_dedup_filter_tb;
    import mdf_pkg::*;

    localparam int          CLK_HALF   = 10;
    localparam int          SET_SIZE   = SEEN_CAPACITY_DEF;
    localparam int unsigned CYCLE_CAP  = 3_000_000;
    localparam int          RECENT_MAX = 64;

    logic     clk     = 1'b0;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    mdf_req_t request = '0;
    logic     busy;
    logic     done;
    mdf_res_t result;

    // bench copy of the filter state
    logic [ADDR_W-1:0] seen_addr [SET_SIZE];
    int                seen_cnt  = 0;
    logic [CNT_W-1:0]  wifi_cnt  = '0;
    logic [CNT_W-1:0]  ble_cnt   = '0;
    logic [CNT_W-1:0]  clear_cnt = '0;

    mdf_res_t          outcome_q   [$];
    logic [ADDR_W-1:0] recent_addr [$];

    int          errors      = 0;
    int unsigned cycle_count = 0;
    bit          idling      = 1'b0;
    int          burst_left  = 0;

    mac_address_dedup_filter u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        return ADDR_W'({$urandom(), $urandom()});
    endfunction

    // clear a full set, look up, insert a fresh valid address, count
    function automatic mdf_res_t dedup_outcome(input mdf_req_t req);
        mdf_res_t res;
        logic     hit;
        res = '0;
        hit = 1'b0;
        if (seen_cnt >= SET_SIZE)
        begin
            seen_cnt          = 0;
            clear_cnt         = bump(clear_cnt);
            res.cache_flushed = 1'b1;
        end
        if (req.address_ok)
            for (int i = 0; i < seen_cnt; i++)
                if (seen_addr[i] == req.device_address)
                    hit = 1'b1;
        res.is_new = !hit;
        if (!hit)
        begin
            if (req.address_ok)
            begin
                seen_addr[seen_cnt] = req.device_address;
                seen_cnt++;
            end
            if (req.source_kind)
                ble_cnt = bump(ble_cnt);
            else
                wifi_cnt = bump(wifi_cnt);
        end
        res.wifi_total  = wifi_cnt;
        res.ble_total   = ble_cnt;
        res.flush_total = clear_cnt;
        return res;
    endfunction

    // result checker: done is sampled as it stood in the cycle just ended
    always @(posedge clk)
    begin : score
        mdf_res_t want;
        if (rst_n && done)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result with no request outstanding: %h", result);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (result.is_new !== want.is_new)
                begin
                    $error("is_new: expected %0d, got %0d", want.is_new, result.is_new);
                    errors++;
                end
                if (result.cache_flushed !== want.cache_flushed)
                begin
                    $error("cache_flushed: expected %0d, got %0d",
                           want.cache_flushed, result.cache_flushed);
                    errors++;
                end
                if (result.wifi_total !== want.wifi_total)
                begin
                    $error("wifi_total: expected %0d, got %0d",
                           want.wifi_total, result.wifi_total);
                    errors++;
                end
                if (result.ble_total !== want.ble_total)
                begin
                    $error("ble_total: expected %0d, got %0d",
                           want.ble_total, result.ble_total);
                    errors++;
                end
                if (result.flush_total !== want.flush_total)
                begin
                    $error("flush_total: expected %0d, got %0d",
                           want.flush_total, result.flush_total);
                    errors++;
                end
            end
        end
    end

    // holds start until the request is taken; start is left high
    task automatic send_request(input logic [ADDR_W-1:0] addr, input logic ok,
                                input logic kind);
        mdf_req_t req;
        req.device_address = addr;
        req.address_ok     = ok;
        req.source_kind    = kind;
        start   <= 1'b1;
        request <= req;
        do @(posedge clk); while (busy);
        outcome_q.push_back(dedup_outcome(req));
        if (ok)
        begin
            recent_addr.push_back(addr);
            if (recent_addr.size() > RECENT_MAX)
                void'(recent_addr.pop_front());
        end
    endtask

    // bursts of back-to-back requests with gaps, some landing around done
    task automatic pace();
        int unsigned gap;
        if (!idling)
            return;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 10);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(SET_SIZE - 2, SET_SIZE + 8)
                                           : $urandom_range(1, 3);
        start <= 1'b0;
        repeat (gap) @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0);
    endtask

    task automatic test_directed_cases();
        logic [ADDR_W-1:0] ones;
        ones = '1;
        idling = 1'b0;
        send_request('0, 1'b1, 1'b0);
        send_request('0, 1'b1, 1'b0);
        send_request('0, 1'b1, 1'b1);
        send_request(ones, 1'b1, 1'b1);
        send_request(ones, 1'b1, 1'b0);
        // unparsed address already in the set: still new
        send_request(ones, 1'b0, 1'b0);
        send_request(ones, 1'b0, 1'b1);
        send_request({ADDR_W/2{2'b01}}, 1'b1, 1'b0);
        send_request({ADDR_W/2{2'b10}}, 1'b1, 1'b1);
        send_request({ADDR_W/2{2'b10}}, 1'b0, 1'b1);
        send_request({ADDR_W/2{2'b10}}, 1'b1, 1'b0);
        // unparsed address is never inserted
        send_request(48'h0123_4567_89AB, 1'b0, 1'b0);
        send_request(48'h0123_4567_89AB, 1'b1, 1'b1);
        send_request(48'h0123_4567_89AB, 1'b1, 1'b0);
        send_request(48'h8000_0000_0000, 1'b1, 1'b0);
        send_request(48'h0000_0000_0001, 1'b1, 1'b1);
        send_request(48'h8000_0000_0000, 1'b1, 1'b1);
        send_request(48'h0000_0000_0001, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_fill_to_clear();
        logic [ADDR_W-1:0] last_addr;
        last_addr = '0;
        idling = 1'b0;
        while (seen_cnt < SET_SIZE)
        begin
            last_addr = rand_addr();
            send_request(last_addr, 1'b1, 1'($urandom_range(0, 1)));
        end
        // set is full: the next request clears it first, so this misses
        send_request(last_addr, 1'b1, 1'b0);
        send_request(last_addr, 1'b1, 1'b1);
        send_request(48'h0000_0000_0001, 1'b1, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int unsigned       sel;
        logic [ADDR_W-1:0] addr;
        idling = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 50 || recent_addr.size() == 0)
                addr = rand_addr();
            else
                addr = recent_addr[$urandom_range(0, recent_addr.size() - 1)];
            send_request(addr, sel < 85, 1'($urandom_range(0, 1)));
            if (n % 250 == 249)
                wait_drained();
            else
                pace();
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_fill_to_clear();
        test_random_traffic(1020);
        repeat (SET_SIZE + 8) @(posedge clk);
        if (errors == 0 && outcome_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
